// File: sv/hpst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpst_pkg
// Shared types and constants for the harmonic peak select / THD block.
// ----------------------------------------------------------------------------
package hpst_pkg;

  localparam int FFT_POINTS_DEF = 1024;
  localparam int NUM_PEAKS      = 5;
  localparam int ADDR_MAX_W     = 12;

  localparam logic [17:0] NOISE_FLOOR_RST = 18'd50;
  localparam logic [19:0] SAMPLE_RATE_RST = 20'd86000;
  localparam logic [26:0] THD_SCALE       = 27'd100000000;
  localparam logic [14:0] THD_MAX         = 15'h7fff;

  localparam logic [7:0] REG_NOISE_FLOOR = 8'd0;
  localparam logic [7:0] REG_SAMPLE_RATE = 8'd1;

  typedef struct packed {
    logic [17:0] magnitude;
    logic        last_bin;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  rank;
    logic [8:0]  bin_index;
    logic [18:0] frequency_hz;
    logic [17:0] amplitude;
    logic [14:0] thd_hundredths;
    logic        thd_valid;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_MAX_W-1:0] addr;
    logic [17:0]           data;
  } mem_wr_t;

  typedef struct packed {
    logic scan_busy;
    logic idle;
  } back_stat_t;

endpackage

// File: sv/hpst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpst_front
// Bin loader: applies the noise floor, writes bins, posts frame lengths.
// ----------------------------------------------------------------------------
module hpst_front import hpst_pkg::*; #(
  parameter int HALF = FFT_POINTS_DEF / 2,
  parameter int AW   = $clog2(HALF),
  parameter int LW   = AW + 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  input  logic [17:0] noise_floor,
  input  logic        allow,
  output mem_wr_t     wr,
  output logic        push,
  output logic [LW-1:0] push_len
);

  logic [LW-1:0] pos;
  logic          acc;
  logic          room;

  assign in_ready = allow;
  assign acc      = in_valid && in_ready;
  assign room     = pos < LW'(HALF);

  assign wr.en    = acc && room;
  assign wr.addr  = ADDR_MAX_W'(pos[AW-1:0]);
  assign wr.data  = (in_data.magnitude <= noise_floor) ? 18'd0 : in_data.magnitude;
  assign push     = acc && in_data.last_bin;
  assign push_len = room ? pos + LW'(1) : pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (acc) begin
      if (in_data.last_bin) begin
        pos <= '0;
      end else if (room) begin
        pos <= pos + LW'(1);
      end
    end
  end

endmodule

// File: sv/hpst_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpst_fifo
// Two-entry queue of frame lengths between loader and selector.
// ----------------------------------------------------------------------------
module hpst_fifo #(
  parameter int W = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  logic [W-1:0] q [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;

  assign empty    = cnt == 2'd0;
  assign pop_data = q[rp];

  always_ff @(posedge clk) begin
    if (push && cnt != 2'd2) begin
      q[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && cnt != 2'd2) begin
        wp <= ~wp;
      end
      if (pop && !empty) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'((push && cnt != 2'd2) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

// File: sv/hpst_thd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpst_thd
// THD unit: t = min(floor(isqrt(1e8*s) / m), 32767), bit serial.
// ----------------------------------------------------------------------------
module hpst_thd import hpst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [37:0] s,
  input  logic [17:0] m,
  output logic        done,
  output logic [14:0] t
);

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_MUL  = 4'b0010,
    T_SQRT = 4'b0100,
    T_DIV  = 4'b1000
  } tstate_t;

  tstate_t     state;
  logic [18:0] s_hi;
  logic [17:0] m_r;
  logic [65:0] r;
  logic [36:0] rem;
  logic [32:0] root;
  logic [32:0] quot;
  logic [17:0] drem;
  logic [5:0]  cnt;
  logic [18:0] mul_a;
  logic [45:0] prod;
  logic [36:0] rem_sh;
  logic [36:0] trial;
  logic [18:0] dsh;

  assign mul_a  = (state == T_IDLE) ? s[18:0] : s_hi;
  assign prod   = 46'(mul_a) * 46'(THD_SCALE);
  assign rem_sh = {rem[34:0], r[65:64]};
  assign trial  = {2'b00, root, 2'b01};
  assign dsh    = {drem, root[32]};
  assign t      = (|quot[32:15]) ? THD_MAX : quot[14:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= (state == T_DIV) && (cnt == 6'd32);
      case (state)
        T_IDLE: begin
          if (start) begin
            s_hi  <= s[37:19];
            m_r   <= m;
            r     <= 66'(prod);
            state <= T_MUL;
          end
        end
        T_MUL: begin
          r     <= r + 66'({prod, 19'd0});
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= T_SQRT;
        end
        T_SQRT: begin
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[31:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[31:0], 1'b0};
          end
          r <= {r[63:0], 2'b00};
          if (cnt == 6'd32) begin
            cnt   <= '0;
            drem  <= '0;
            quot  <= '0;
            state <= T_DIV;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        T_DIV: begin
          if (dsh >= {1'b0, m_r}) begin
            drem <= 18'(dsh - {1'b0, m_r});
            quot <= {quot[31:0], 1'b1};
          end else begin
            drem <= dsh[17:0];
            quot <= {quot[31:0], 1'b0};
          end
          root <= {root[31:0], 1'b0};
          if (cnt == 6'd32) begin
            state <= T_IDLE;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

// File: sv/hpst_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpst_back
// Bin store, five peak scans, sum of squares, THD and row output.
// ----------------------------------------------------------------------------
module hpst_back import hpst_pkg::*; #(
  parameter int HALF = FFT_POINTS_DEF / 2,
  parameter int AW   = $clog2(HALF),
  parameter int LW   = AW + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  mem_wr_t       wr,
  input  logic          q_empty,
  input  logic [LW-1:0] q_len,
  output logic          q_pop,
  input  logic [19:0]   sample_rate,
  output back_stat_t    stat,
  output logic          out_valid,
  input  logic          out_ready,
  output out_item_t     out_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_SQ   = 5'b00100,
    S_THD  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  localparam int PW = AW + 20;

  state_t        state;
  logic [17:0]   mem [HALF];
  logic [17:0]   rdata;
  logic [2:0]    k;
  logic [LW-1:0] len;
  logic [LW-1:0] ra;
  logic [LW-1:0] da;
  logic          iss;
  logic          rv;
  logic [17:0]   p;
  logic [17:0]   c;
  logic [17:0]   best;
  logic [AW-1:0] best_bin;
  logic [AW-1:0] chosen_bins [NUM_PEAKS];
  logic [17:0]   chosen_amplitudes [NUM_PEAKS];
  logic [37:0]   sumsq;
  logic          thd_start;
  logic          thd_done;
  logic [14:0]   thd_t;
  logic [14:0]   thd;
  logic          thd_ok;

  logic [17:0]   d;
  logic [LW-1:0] i_idx;
  logic          skip;
  logic          cand;
  logic          pass_end;
  logic [17:0]   best_next;
  logic [AW-1:0] bin_next;
  logic [35:0]   sq;
  logic [PW-1:0] fprod;
  logic [11:0]   bin_wide;
  logic          load;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    rdata <= mem[ra[AW-1:0]];
  end

  assign d        = (da < len) ? rdata : 18'd0;
  assign i_idx    = da - LW'(1);
  assign pass_end = rv && (da == len);

  always_comb begin
    skip = 1'b0;
    for (int j = 0; j < NUM_PEAKS; j++) begin
      if (3'(j) < k && chosen_bins[j] == i_idx[AW-1:0]) begin
        skip = 1'b1;
      end
    end
  end

  assign cand = rv && (da >= LW'(2)) && (c > best) &&
                (k == 3'd0 || (!skip && c > d && c > p));
  assign best_next = cand ? c : best;
  assign bin_next  = cand ? i_idx[AW-1:0] : best_bin;

  assign sq       = chosen_amplitudes[k] * chosen_amplitudes[k];
  assign fprod    = PW'(chosen_bins[k]) * PW'(sample_rate);
  assign bin_wide = 12'(chosen_bins[k]);
  assign load     = (state == S_EMIT) && (!out_valid || out_ready);

  assign q_pop          = (state == S_IDLE) && !q_empty;
  assign stat.scan_busy = state == S_SCAN;
  assign stat.idle      = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      iss       <= 1'b0;
      rv        <= 1'b0;
      k         <= '0;
      thd_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      thd_start <= (state == S_SQ) && (k == 3'(NUM_PEAKS - 1));
      rv        <= iss;
      da        <= ra;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            len      <= q_len;
            k        <= '0;
            ra       <= '0;
            iss      <= 1'b1;
            best     <= '0;
            best_bin <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (iss) begin
            ra <= ra + LW'(1);
            if (ra == len) begin
              iss <= 1'b0;
            end
          end
          if (rv) begin
            p <= c;
            c <= d;
          end
          best     <= pass_end ? 18'd0 : best_next;
          best_bin <= pass_end ? '0 : bin_next;
          if (pass_end) begin
            chosen_bins[k]       <= bin_next;
            chosen_amplitudes[k] <= best_next;
            if (k == 3'(NUM_PEAKS - 1)) begin
              k     <= 3'd1;
              sumsq <= '0;
              state <= S_SQ;
            end else begin
              k   <= k + 3'd1;
              ra  <= '0;
              iss <= 1'b1;
            end
          end
        end
        S_SQ: begin
          sumsq <= sumsq + 38'(sq);
          if (k == 3'(NUM_PEAKS - 1)) begin
            state <= S_THD;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_THD: begin
          if (thd_done) begin
            thd_ok <= chosen_amplitudes[0] != 18'd0;
            thd    <= (chosen_amplitudes[0] != 18'd0) ? thd_t : 15'd0;
            k      <= '0;
            state  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load) begin
            out_data.rank           <= k;
            out_data.bin_index      <= bin_wide[8:0];
            out_data.frequency_hz   <= fprod[AW+19:AW+1];
            out_data.amplitude      <= chosen_amplitudes[k];
            out_data.thd_hundredths <= thd;
            out_data.thd_valid      <= thd_ok;
            out_data.last           <= k == 3'(NUM_PEAKS - 1);
            if (k == 3'(NUM_PEAKS - 1)) begin
              state <= S_IDLE;
            end else begin
              k <= k + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  hpst_thd u_thd (
    .clk   (clk),
    .rst   (rst),
    .start (thd_start),
    .s     (sumsq),
    .m     (chosen_amplitudes[0]),
    .done  (thd_done),
    .t     (thd_t)
  );

endmodule

// File: sv/harmonic_peak_select_thd_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// harmonic_peak_select_thd_top
// Picks the five largest spectral peaks of a frame and reports THD.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one half-spectrum bin per transfer, bin 0 first; last_bin ends
//           the frame. Bins past FFT_POINTS/2 are dropped.
//   out_* : five rows per frame, rank 0 to 4, last set on rank 4.
//   cfg_* : register writes (0 noise floor, 1 sample rate), always ready;
//           write only while the block is idle.
// Throughput: bins load at one per cycle unless input is held off. After
//   last_bin the selector makes five scans over the stored bins (one read
//   per cycle from the single bin store read port), then forms the sum of
//   squares and runs the bit-serial square root and divider, then emits five
//   rows. Input is held off while a scan runs or a frame length is queued;
//   the next frame can load during THD and row output.
// FFT_POINTS must be a power of two.
// Reset clears all control state and restores register defaults; the bin
//   store needs no clearing. A stalled receiver holds the current row and
//   pauses the row sequence.
// ----------------------------------------------------------------------------
module harmonic_peak_select_thd_top import hpst_pkg::*; #(
  parameter int FFT_POINTS = FFT_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int HALF = FFT_POINTS / 2;
  localparam int AW   = $clog2(HALF);
  localparam int LW   = AW + 1;

  logic [17:0]   noise_floor;
  logic [19:0]   sample_rate;
  mem_wr_t       wr;
  logic          push;
  logic [LW-1:0] push_len;
  logic          q_pop;
  logic          q_empty;
  logic [LW-1:0] q_len;
  back_stat_t    stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_floor <= NOISE_FLOOR_RST;
      sample_rate <= SAMPLE_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_NOISE_FLOOR) begin
        noise_floor <= cfg_data[17:0];
      end else if (cfg_index == REG_SAMPLE_RATE) begin
        sample_rate <= cfg_data;
      end
    end
  end

  hpst_front #(.HALF(HALF), .AW(AW), .LW(LW)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .noise_floor (noise_floor),
    .allow       (q_empty && !stat.scan_busy),
    .wr          (wr),
    .push        (push),
    .push_len    (push_len)
  );

  hpst_fifo #(.W(LW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_len),
    .pop       (q_pop),
    .pop_data  (q_len),
    .empty     (q_empty)
  );

  hpst_back #(.HALF(HALF), .AW(AW), .LW(LW)) u_back (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .q_empty     (q_empty),
    .q_len       (q_len),
    .q_pop       (q_pop),
    .sample_rate (sample_rate),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

`ifndef ASSERT_OFF
  a_no_load_in_scan: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !stat.scan_busy)
    else $error("input accepted during scan");
  a_last_rank: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> out_data.rank == 3'(NUM_PEAKS - 1))
    else $error("last flag on wrong rank");
  a_thd_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.thd_valid |-> out_data.thd_hundredths == 15'd0)
    else $error("thd nonzero while invalid");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> stat.idle && !q_empty)
    else $error("frame popped while busy");
`endif

endmodule

// File: bench/harmonic_peak_select_thd_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// harmonic_peak_select_thd_top_tb
// Self-checking bench for the harmonic peak select / THD block. Frames of
// spectrum bins are sent with random bursts and gaps, the block's five peak
// rows are predicted per frame and checked field by field in order, and the
// noise floor and sample rate registers are swept between phases.
// ----------------------------------------------------------------------------
module harmonic_peak_select_thd_top_tb;
  import hpst_pkg::*;

  localparam int POINTS = FFT_POINTS_DEF;
  localparam int HALF   = POINTS / 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  harmonic_peak_select_thd_top #(.FFT_POINTS(POINTS)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [17:0] spectrum [HALF];
  int unsigned fill_count;
  logic [17:0] floor_reg;
  logic [19:0] rate_reg;
  out_item_t   peak_rows [$];
  int          errors;
  int          bins_sent;
  int          frames_sent;
  int          rows_seen = 0;
  int          burst_left;
  bit          stall_mode = 1'b0;

  function automatic logic [17:0] bin_value(int i, int n);
    if (i < 0 || i >= n || i >= HALF) return '0;
    return spectrum[i];
  endfunction

  function automatic logic [14:0] thd_of(logic [63:0] s, logic [63:0] m);
    logic [127:0] lim;
    logic [127:0] sq;
    logic [14:0]  t;
    logic [14:0]  cand;
    lim = 128'(s) * 128'(100000000);
    t = '0;
    for (int b = 14; b >= 0; b--) begin
      cand = t | (15'd1 << b);
      sq = 128'(cand) * 128'(m);
      sq = sq * sq;
      if (sq <= lim) t = cand;
    end
    return t;
  endfunction

  task automatic predict_frame();
    int          n;
    logic [8:0]  pk_bin [NUM_PEAKS];
    logic [17:0] pk_amp [NUM_PEAKS];
    logic [17:0] best;
    logic [17:0] v;
    int          best_bin;
    bit          skip;
    logic [63:0] sumsq;
    logic [14:0] thd;
    out_item_t   row;
    n = fill_count;
    best = '0;
    best_bin = 0;
    for (int i = 1; i < n; i++) begin
      v = bin_value(i, n);
      if (v > best) begin
        best = v;
        best_bin = i;
      end
    end
    pk_bin[0] = best_bin[8:0];
    pk_amp[0] = best;
    for (int k = 1; k < NUM_PEAKS; k++) begin
      best = '0;
      best_bin = 0;
      for (int i = 1; i < n; i++) begin
        v = bin_value(i, n);
        skip = 1'b0;
        for (int j = 0; j < k; j++) if (pk_bin[j] == i[8:0]) skip = 1'b1;
        if (!skip && v > best && v > bin_value(i + 1, n) && v > bin_value(i - 1, n)) begin
          best = v;
          best_bin = i;
        end
      end
      pk_bin[k] = best_bin[8:0];
      pk_amp[k] = best;
    end
    sumsq = '0;
    for (int k = 1; k < NUM_PEAKS; k++) sumsq += 64'(pk_amp[k]) * 64'(pk_amp[k]);
    thd = (pk_amp[0] != 0) ? thd_of(sumsq, 64'(pk_amp[0])) : '0;
    for (int k = 0; k < NUM_PEAKS; k++) begin
      row.rank = 3'(k);
      row.bin_index = pk_bin[k];
      row.frequency_hz = 19'((64'(pk_bin[k]) * 64'(rate_reg)) / POINTS);
      row.amplitude = pk_amp[k];
      row.thd_hundredths = thd;
      row.thd_valid = (pk_amp[0] != 0);
      row.last = (k == NUM_PEAKS - 1);
      peak_rows.push_back(row);
    end
    fill_count = 0;
  endtask

  task automatic send_bin(logic [17:0] mag, bit last_bin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{magnitude: mag, last_bin: last_bin};
    do @(posedge clk); while (!in_ready);
    if (fill_count < HALF) begin
      spectrum[fill_count] = (mag <= floor_reg) ? '0 : mag;
      fill_count++;
    end
    bins_sent++;
    if (last_bin) begin
      frames_sent++;
      predict_frame();
    end
  endtask

  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    burst_left = 0;
    guard = 0;
    while (peak_rows.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (5 * (HALF + 3) + 100) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [19:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_NOISE_FLOOR) floor_reg = value[17:0];
    else if (idx == REG_SAMPLE_RATE) rate_reg = value;
  endtask

  task automatic send_frame(int n, int style);
    logic [17:0] m;
    for (int i = 0; i < n; i++) begin
      case (style)
        0: m = 18'($urandom_range(0, 262143));
        1: m = (i % 7 == 3) ? 18'($urandom_range(1000, 262143)) : 18'($urandom_range(0, 80));
        2: m = 18'($urandom_range(0, 3));
        default: m = 18'($urandom_range(0, 200));
      endcase
      send_bin(m, i == n - 1);
    end
  endtask

  // row checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      rows_seen++;
      if (peak_rows.size() == 0) begin
        $display("%0t: unexpected row %p", $time, out_data);
        errors++;
      end else begin
        want = peak_rows.pop_front();
        if (out_data.rank !== want.rank)
          $display("%0t: rank exp %0d got %0d", $time, want.rank, out_data.rank);
        if (out_data.bin_index !== want.bin_index)
          $display("%0t: bin exp %0d got %0d", $time, want.bin_index, out_data.bin_index);
        if (out_data.frequency_hz !== want.frequency_hz)
          $display("%0t: freq exp %0d got %0d", $time, want.frequency_hz,
                   out_data.frequency_hz);
        if (out_data.amplitude !== want.amplitude)
          $display("%0t: amp exp %0d got %0d", $time, want.amplitude, out_data.amplitude);
        if (out_data.thd_hundredths !== want.thd_hundredths)
          $display("%0t: thd exp %0d got %0d", $time, want.thd_hundredths,
                   out_data.thd_hundredths);
        if (out_data.thd_valid !== want.thd_valid)
          $display("%0t: thd_valid exp %0b got %0b", $time, want.thd_valid,
                   out_data.thd_valid);
        if (out_data.last !== want.last)
          $display("%0t: last exp %0b got %0b", $time, want.last, out_data.last);
        if (out_data !== want) errors++;
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  task automatic test_directed();
    // single-bin frame, all-zero frame, extremes, ties
    send_bin(18'h3ffff, 1'b1);
    send_frame(6, 2);
    send_bin(18'd0, 1'b0);
    send_bin(18'h3ffff, 1'b0);
    send_bin(18'h3ffff, 1'b0);
    send_bin(18'd51, 1'b0);
    send_bin(18'd50, 1'b0);
    send_bin(18'd200, 1'b0);
    send_bin(18'd100, 1'b0);
    send_bin(18'h2aaaa, 1'b0);
    send_bin(18'h15555, 1'b0);
    send_bin(18'd300, 1'b1);
    send_bin(18'd0, 1'b0);
    send_bin(18'd900, 1'b0);
    send_bin(18'd800, 1'b1);
    drain();
  endtask

  task automatic test_registers();
    write_reg(REG_NOISE_FLOOR, 20'd0);
    write_reg(REG_SAMPLE_RATE, 20'd1000000);
    send_frame(8, 3);
    drain();
    write_reg(REG_NOISE_FLOOR, 20'hfffff);
    write_reg(REG_SAMPLE_RATE, 20'd1);
    write_reg(8'd7, 20'd12345);
    send_frame(8, 0);
    drain();
    write_reg(REG_NOISE_FLOOR, 20'd262142);
    write_reg(REG_SAMPLE_RATE, 20'hfffff);
    send_bin(18'h3ffff, 1'b0);
    send_bin(18'd5, 1'b1);
    drain();
  endtask

  task automatic test_overflow();
    write_reg(REG_NOISE_FLOOR, 20'd50);
    write_reg(REG_SAMPLE_RATE, 20'd86000);
    send_frame(HALF + 3, 0);
    drain();
  endtask

  task automatic test_random();
    int rounds;
    rounds = 0;
    while (bins_sent < 310 + HALF + 60) begin
      if (rounds % 8 == 7) begin
        drain();
        write_reg(REG_NOISE_FLOOR, 20'($urandom_range(0, 2000)));
        write_reg(REG_SAMPLE_RATE, 20'($urandom_range(1, 1000000)));
      end
      send_frame($urandom_range(1, 16), $urandom_range(0, 3));
      rounds++;
    end
    drain();
  endtask

  initial begin
    errors = 0;
    bins_sent = 0;
    frames_sent = 0;
    burst_left = 0;
    fill_count = 0;
    floor_reg = NOISE_FLOOR_RST;
    rate_reg = SAMPLE_RATE_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_registers();
    test_overflow();
    test_random();
    if (peak_rows.size() != 0) begin
      $display("%0t: %0d rows never arrived", $time, peak_rows.size());
      errors++;
    end
    $display("Covered %0d bins in %0d frames, %0d peak rows checked, %0d errors.",
             bins_sent, frames_sent, rows_seen, errors);
    if (errors == 0) $display("harmonic_peak_select_thd_top test passed");
    else $display("harmonic_peak_select_thd_top test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("harmonic_peak_select_thd_top test failed");
    $finish;
  end

endmodule
